// File: design/isr_pkg.sv
// Shared constants and helpers for the iterative square root unit.
// Used by the serial divider, the serial multiplier and the top level.
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

   localparam int DATA_W         = 32;
   localparam int FRAC_BITS      = 16;
   localparam int MAX_ITERATIONS = 15;
   localparam int ITER_W         = 4;
   localparam int DIVD_W         = DATA_W + FRAC_BITS;
   localparam int PROD_W         = DIVD_W + DATA_W;
   localparam int CSR_IDX_W      = 2;
   localparam int STATUS_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_METHOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT      = 2'd2;

   localparam logic [DIVD_W-1:0] THREE_Q   = DIVD_W'(3) << FRAC_BITS;
   localparam logic [DIVD_W-1:0] RECIP_NUM = DIVD_W'(1) << (2 * FRAC_BITS);

   localparam logic [31:0] START_RESET = 32'd131072;
   localparam logic [ITER_W-1:0] ITER_RESET = 4'd3;

   function automatic logic over_data(input logic [PROD_W-1:0] v);
      return |v[PROD_W-1:DATA_W];
   endfunction

   function automatic logic [DATA_W-1:0] sat_data(input logic [PROD_W-1:0] v);
      return over_data(v) ? {DATA_W{1'b1}} : v[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: design/isr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on isr_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module isr_div
   import isr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DATA_W-1:0] divisor,
   output logic                   busy,
   output logic                   done,
   output logic [DIVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] div_ff, div_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      diff    = trial - {1'b0, div_ff};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: design/isr_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on isr_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module isr_mul
   import isr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] mcand,
   input  wire logic [DATA_W-1:0] mplier,
   output logic                   busy,
   output logic                   done,
   output logic [PROD_W-1:0]      product
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIVD_W:0]   sum;

   always_comb begin
      // The upper half accumulates while the multiplier bits shift out below.
      sum = {1'b0, prod_ff[PROD_W-1:DATA_W]}
          + (prod_ff[0] ? {1'b0, mcand_ff} : {(DIVD_W + 1){1'b0}});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         prod_in  = {{DIVD_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[DATA_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = prod_ff;

endmodule

`default_nettype wire

// File: design/iterative_square_root_unit.sv
// Top level of the iterative square root unit: registers, sequencer, result register.
// Depends on isr_pkg, isr_div and isr_mul.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operand_value
//   rsp      out        rsp_valid/rsp_stall  root_value, status_code
//   csr      in         csr_valid/csr_ready  index, wdata
//
// One item at a time. Babylonian mode runs one bit-serial division (48 quotient
// bits) per iteration. Newton mode runs a division for the reciprocal, up to
// three multiplies per iteration and a final product. The result register frees
// the datapath once loaded.
// Reset is synchronous and restores the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module iterative_square_root_unit
   import isr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [DATA_W-1:0]    req_operand_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [DATA_W-1:0]         rsp_root_value,
   output logic [STATUS_W-1:0]       rsp_status_code,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_BCHK = 4'd1;
   localparam logic [3:0] S_BDIV = 4'd2;
   localparam logic [3:0] S_NREC = 4'd3;
   localparam logic [3:0] S_NCHK = 4'd4;
   localparam logic [3:0] S_NSQ  = 4'd5;
   localparam logic [3:0] S_NU   = 4'd6;
   localparam logic [3:0] S_NRD  = 4'd7;
   localparam logic [3:0] S_NFIN = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic                method_ff;
   logic [DATA_W-1:0]   start_ff;
   logic [ITER_W-1:0]   iter_ff;

   logic [3:0]          state_ff, state_in;
   logic [DATA_W-1:0]   x_ff, x_in;
   logic [DATA_W-1:0]   a_ff, a_in;
   logic [ITER_W-1:0]   n_ff, n_in;
   logic [ITER_W-1:0]   cnt_ff, cnt_in;
   logic                sat_ff, sat_in;
   logic                divz_ff, divz_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_root_ff, rsp_root_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                div_start, div_busy, div_done;
   logic [DIVD_W-1:0]   div_dividend, div_quo;
   logic [DATA_W-1:0]   div_divisor;
   logic                mul_start, mul_busy, mul_done;
   logic [DIVD_W-1:0]   mul_mcand;
   logic [DATA_W-1:0]   mul_mplier;
   logic [PROD_W-1:0]   mul_prod;

   logic                req_take, rsp_free;
   logic [PROD_W-1:0]   bab_val, rec_val, nrd_val, fin_val;
   logic [DIVD_W-1:0]   s_val, d_val;
   logic                u_over;

   isr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   isr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= 1'b0;
         start_ff  <= START_RESET;
         iter_ff   <= ITER_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_METHOD: method_ff <= csr_wdata[0];
            CSR_START:  start_ff  <= csr_wdata;
            CSR_ITER:   iter_ff   <= csr_wdata[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      bab_val = (PROD_W'(a_ff) + PROD_W'(div_quo)) >> 1;
      rec_val = PROD_W'(div_quo);
      nrd_val = mul_prod >> (FRAC_BITS + 1);
      fin_val = mul_prod >> FRAC_BITS;
      s_val   = mul_prod[FRAC_BITS +: DIVD_W];
      // A product that would have saturated is far above three, so the exact
      // compare covers the saturating case as well.
      u_over  = mul_prod[PROD_W-1:FRAC_BITS] > (PROD_W - FRAC_BITS)'(THREE_Q);
      d_val   = THREE_Q - mul_prod[FRAC_BITS +: DIVD_W];
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      a_in          = a_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      sat_in        = sat_ff;
      divz_in       = divz_ff;
      div_start     = 1'b0;
      div_dividend  = {x_ff, {FRAC_BITS{1'b0}}};
      div_divisor   = a_ff;
      mul_start     = 1'b0;
      mul_mcand     = DIVD_W'(a_ff);
      mul_mplier    = x_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_root_in   = rsp_root_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               x_in    = req_operand_value;
               n_in    = (32'(iter_ff) > MAX_ITERATIONS) ? ITER_W'(MAX_ITERATIONS)
                                                          : iter_ff;
               cnt_in  = '0;
               sat_in  = 1'b0;
               divz_in = 1'b0;
               a_in    = start_ff;
               if (!method_ff) begin
                  state_in = S_BCHK;
               end else if (start_ff == '0) begin
                  divz_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = RECIP_NUM;
                  div_divisor  = start_ff;
                  state_in     = S_NREC;
               end
            end
         end
         S_BCHK: begin
            if (cnt_ff == n_ff) begin
               state_in = S_DONE;
            end else if (a_ff == '0) begin
               divz_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_BDIV;
            end
         end
         S_BDIV: begin
            if (div_done) begin
               a_in     = sat_data(bab_val);
               sat_in   = sat_ff || over_data(bab_val);
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_BCHK;
            end
         end
         S_NREC: begin
            if (div_done) begin
               a_in     = sat_data(rec_val);
               sat_in   = sat_ff || over_data(rec_val);
               state_in = S_NCHK;
            end
         end
         S_NCHK: begin
            mul_start = 1'b1;
            if (cnt_ff == n_ff) begin
               state_in = S_NFIN;
            end else begin
               mul_mplier = a_ff;
               state_in   = S_NSQ;
            end
         end
         S_NSQ: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_mcand = s_val;
               state_in  = S_NU;
            end
         end
         S_NU: begin
            if (mul_done) begin
               if (u_over) begin
                  a_in     = '0;
                  sat_in   = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_NCHK;
               end else begin
                  mul_start  = 1'b1;
                  mul_mplier = d_val[DATA_W-1:0];
                  state_in   = S_NRD;
               end
            end
         end
         S_NRD: begin
            if (mul_done) begin
               a_in     = sat_data(nrd_val);
               sat_in   = sat_ff || over_data(nrd_val);
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_NCHK;
            end
         end
         S_NFIN: begin
            if (mul_done) begin
               a_in     = sat_data(fin_val);
               sat_in   = sat_ff || over_data(fin_val);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (divz_ff) begin
                  rsp_root_in   = '0;
                  rsp_status_in = ST_DIV_ZERO;
               end else begin
                  rsp_root_in   = a_ff;
                  rsp_status_in = sat_ff ? ST_SAT : ST_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      a_ff          <= a_in;
      n_ff          <= n_in;
      cnt_ff        <= cnt_in;
      sat_ff        <= sat_in;
      divz_ff       <= divz_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_value  = rsp_root_ff;
   assign rsp_status_code = rsp_status_ff;

`ifndef SYNTHESIS
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after taking an item");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_busy && mul_busy))
      else $error("divider and multiplier busy together");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_code != 2'd3)
      else $error("illegal status code on result");

   a_divzero_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code == ST_DIV_ZERO |-> rsp_root_value == '0)
      else $error("division by zero result carries a nonzero root");
`endif

endmodule

`default_nettype wire

// File: sim/tb_iterative_square_root_unit.sv
// Self-checking testbench for the iterative square root unit.
// Depends on isr_pkg and the design files; predicts each root from the register settings.
`timescale 1ns / 1ps

module tb_iterative_square_root_unit;
   import isr_pkg::*;

   localparam int F = FRAC_BITS;
   localparam logic [63:0] MAXW = 64'hFFFF_FFFF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0]   root;
      logic [STATUS_W-1:0] status;
   } root_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DATA_W-1:0]    req_operand_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DATA_W-1:0]    rsp_root_value;
   logic [STATUS_W-1:0]  rsp_status_code;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   int  fail_count = 0;
   bit  quiet = 0;
   int  hold_cycles = 0;

   logic                  cfg_newton;
   logic [31:0]           cfg_start;
   logic [ITER_W-1:0]     cfg_iters;

   iterative_square_root_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic logic [63:0] clip32(input logic [63:0] v, inout bit sat);
      if (v > MAXW) begin
         sat = 1;
         return MAXW;
      end
      return v;
   endfunction

   // Expected root for one operand under the current register settings.
   function automatic root_type compute_root(input logic [31:0] xin);
      logic [63:0] x, a, q, r, s, u, three;
      logic [127:0] wide;
      int n;
      bit sat;
      root_type res;
      x = {32'd0, xin};
      sat = 0;
      n = (cfg_iters > MAX_ITERATIONS) ? MAX_ITERATIONS : cfg_iters;
      three = 64'd3 << F;
      if (!cfg_newton) begin
         a = {32'd0, cfg_start};
         for (int i = 0; i < n; i++) begin
            if (a == 0) begin
               res.root = '0;
               res.status = ST_DIV_ZERO;
               return res;
            end
            q = (x << F) / a;
            a = clip32((a + q) >> 1, sat);
         end
      end else begin
         if (cfg_start == 0) begin
            res.root = '0;
            res.status = ST_DIV_ZERO;
            return res;
         end
         r = clip32((64'd1 << (2 * F)) / cfg_start, sat);
         for (int i = 0; i < n; i++) begin
            s = (r * r) >> F;
            wide = x * s;
            u = ((wide > {64'd0, {64{1'b1}}}) ? {64{1'b1}} : wide[63:0]) >> F;
            if (u > three) begin
               r = 0;
               sat = 1;
            end else begin
               r = clip32((r * (three - u)) >> (F + 1), sat);
            end
         end
         a = clip32((r * x) >> F, sat);
      end
      res.root = a[31:0];
      res.status = sat ? ST_SAT : ST_OK;
      return res;
   endfunction

   class root_scoreboard_type;
      root_type pending[$];

      function void note_operand(input logic [31:0] x);
         pending.push_back(compute_root(x));
      endfunction

      task check_root(input logic [31:0] root, input logic [1:0] status);
         root_type exp_r;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result root=%h", root));
            return;
         end
         exp_r = pending.pop_front();
         if (root !== exp_r.root)
            report($sformatf("root %h, expected %h", root, exp_r.root));
         if (status !== exp_r.status)
            report($sformatf("status %0d, expected %0d", status, exp_r.status));
      endtask
   endclass

   root_scoreboard_type sb = new();

   // The monitor samples on the rising edge; the stall generator drives on the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_operand(req_operand_value);
         if (rsp_valid && !rsp_stall)
            sb.check_root(rsp_root_value, rsp_status_code);
      end
   end

   initial begin : stall_gen
      int burst;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_METHOD: cfg_newton = val[0];
         CSR_START:  cfg_start = val;
         CSR_ITER:   cfg_iters = val[ITER_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Valid stays high after an accepted item so that items can follow back to back;
   // it drops only for an idle gap or when the sender stops in drain.
   task automatic send_operand(input logic [31:0] x);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operand_value <= x;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_mode(input bit newton, input logic [31:0] st, input logic [3:0] it);
      drain();
      write_reg(CSR_METHOD, {31'd0, newton});
      write_reg(CSR_START, st);
      write_reg(CSR_ITER, {28'd0, it});
   endtask

   // Mostly realistic operands, with a share of extreme bit patterns.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0004_0000);
         2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom() >> $urandom_range(0, 31);
      endcase
   endfunction

   initial begin : main
      logic [31:0] st;
      cfg_newton = 0;
      cfg_start = START_RESET;
      cfg_iters = ITER_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults straight out of reset.
      send_operand(32'h0004_0000);
      send_operand(32'h0000_0000);
      send_operand(32'hFFFF_FFFF);
      // Babylonian: zero start, zero iterations, maximum iterations.
      set_mode(0, 32'd0, 4'd3);
      send_operand(32'h0001_0000);
      set_mode(0, 32'd0, 4'd0);
      send_operand(32'h0009_0000);
      set_mode(0, 32'hFFFF_FFFF, 4'd15);
      send_operand(32'hFFFF_FFFF);
      send_operand(32'h0000_0001);
      send_operand(32'h0002_0000);
      // Newton: zero start, tiny start saturating the reciprocal, overshoot clamp.
      set_mode(1, 32'd0, 4'd2);
      send_operand(32'h0001_0000);
      set_mode(1, 32'd1, 4'd1);
      send_operand(32'h0001_0000);
      send_operand(32'h0000_0000);
      set_mode(1, 32'h0001_0000, 4'd0);
      send_operand(32'hFFFF_FFFF);
      set_mode(1, 32'h0001_0000, 4'd15);
      send_operand(32'h0000_4000);
      send_operand(32'h0004_0000);
      send_operand(32'hFFFF_FFFF);
      set_mode(1, 32'hFFFF_FFFF, 4'd4);
      send_operand(32'h0001_0000);
      send_operand(32'hAAAA_5555);

      // Long receiver hold while the sender keeps offering items.
      hold_cycles = 2000;
      repeat (6) send_operand(pick_operand());

      for (int phase = 0; phase < 20; phase++) begin
         case ($urandom_range(0, 3))
            0: st = $urandom();
            1: st = $urandom_range(32'h0000_8000, 32'h0004_0000);
            2: st = $urandom_range(0, 3);
            default: st = 32'h0001_0000 << $urandom_range(0, 8);
         endcase
         set_mode(phase[0], st, (phase < 4) ? 4'd15 : 4'($urandom_range(0, 6)));
         if (phase >= 17) quiet = 1;
         repeat (30) send_operand(pick_operand());
         if (phase == 10) drain();
      end
      // A write to the unused index must change nothing.
      drain();
      write_reg(CSR_UNUSED, $urandom());
      repeat (5) send_operand(pick_operand());
      drain();

      if (fail_count == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
